>>> rtl/stf_pkg.sv
`timescale 1ns / 1ps

package stf_pkg;

  // table geometry and result limit
  localparam int TABLE_SIZE_DEF  = 16;
  localparam int MAX_RESULTS_DEF = 16;

  // field widths
  localparam int ID_W      = 16;
  localparam int PAYLOAD_W = 32;
  localparam int REQ_W     = 2;

  // request codes; any other code is a broadcast
  localparam logic [REQ_W-1:0] REQ_JOIN  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LEAVE = 2'd1;

  // one outgoing copy of a broadcast
  typedef struct packed {
    logic [ID_W-1:0]      dest;
    logic [ID_W-1:0]      origin;
    logic [PAYLOAD_W-1:0] payload;
    logic                 last;
  } res_t;

endpackage

>>> rtl/stf_mem.sv
`timescale 1ns / 1ps

module stf_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [stf_pkg::ID_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [stf_pkg::ID_W-1:0] rd_data
);
  import stf_pkg::*;

  logic [ID_W-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, data holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/stf_ctrl.sv
`timescale 1ns / 1ps

module stf_ctrl #(
  parameter int TABLE_SIZE  = 16,
  parameter int MAX_RESULTS = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stf_pkg::REQ_W-1:0]     req_type,
  input  logic [stf_pkg::ID_W-1:0]      sender_id,
  input  logic [stf_pkg::PAYLOAD_W-1:0] payload_handle,
  // result register
  output logic                          res_valid,
  input  logic                          out_stall,
  output stf_pkg::res_t                 res,
  // table memory
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_wa,
  output logic [stf_pkg::ID_W-1:0]      mem_wd,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_ra,
  input  logic [stf_pkg::ID_W-1:0]      rd_data
);
  import stf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_FRD    = 3'd3;
  localparam logic [2:0] S_FEV    = 3'd4;

  logic [2:0]           state, state_next;
  logic [REQ_W-1:0]     kind, kind_next;
  logic [ID_W-1:0]      sender, sender_next;
  logic [PAYLOAD_W-1:0] payload, payload_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        idx, idx_next;
  logic [CW-1:0]        idx_d, idx_d_next;
  logic [CW-1:0]        lim, lim_next;
  logic [CW-1:0]        sent, sent_next;
  logic                 rd_pend, rd_pend_next;
  logic                 res_valid_next;
  res_t                 res_next;

  // shared compare and index arithmetic
  logic          hit;
  logic          more;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_d_inc;
  logic [CW-1:0] idx_d_dec;
  logic [CW-1:0] sent_inc;

  // search decision terms
  logic          found;
  logic          exhausted;
  logic          add;
  logic          present;
  logic [CW-1:0] pos_v;
  logic [CW-1:0] cnt_new;
  logic [CW-1:0] rcpt;
  logic [CW-1:0] lim_v;

  // fanout terms
  logic slot_free;
  logic advance;
  logic load;
  logic is_last;

  assign hit       = (rd_data == sender);
  assign more      = (idx < count);
  assign idx_inc   = CW'(idx + 1'b1);
  assign idx_d_inc = CW'(idx_d + 1'b1);
  assign idx_d_dec = CW'(idx_d - 1'b1);
  assign sent_inc  = CW'(sent + 1'b1);
  assign in_stall  = (state != S_IDLE);
  assign slot_free = !res_valid || !out_stall;

  // outcome of the lookup and the add
  always_comb begin
    found     = rd_pend && hit;
    exhausted = (count == '0) || (rd_pend && !hit && (idx_d_inc == count));
    add       = !found && (count < CW'(TABLE_SIZE));
    present   = found || add;
    pos_v     = found ? idx_d : count;
    cnt_new   = add ? CW'(count + 1'b1) : count;
    rcpt      = CW'(cnt_new - {{(CW-1){1'b0}}, present});
    if (32'(rcpt) > MAX_RESULTS) begin
      lim_v = CW'(MAX_RESULTS);
    end else begin
      lim_v = rcpt;
    end
  end

  // sequencer
  always_comb begin
    state_next   = state;
    kind_next    = kind;
    sender_next  = sender;
    payload_next = payload;
    count_next   = count;
    idx_next     = idx;
    idx_d_next   = idx_d;
    lim_next     = lim;
    sent_next    = sent;
    rd_pend_next = rd_pend;
    mem_we       = 1'b0;
    mem_wa       = count[AW-1:0];
    mem_wd       = sender;
    mem_re       = 1'b0;
    mem_ra       = idx[AW-1:0];
    advance      = 1'b0;
    load         = 1'b0;
    is_last      = (sent_inc == lim);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_next    = req_type;
          sender_next  = sender_id;
          payload_next = payload_handle;
          idx_next     = '0;
          rd_pend_next = 1'b0;
          state_next   = S_SEARCH;
        end
      end

      // pipelined walk, one entry compared per cycle
      S_SEARCH: begin
        if (found || exhausted) begin
          rd_pend_next = 1'b0;
          if (add) begin
            mem_we     = 1'b1;
            count_next = cnt_new;
          end
          case (kind)
            REQ_JOIN: begin
              state_next = S_IDLE;
            end
            REQ_LEAVE: begin
              if (present) begin
                idx_next   = CW'(pos_v + 1'b1);
                state_next = S_SHIFT;
              end else begin
                state_next = S_IDLE;
              end
            end
            default: begin
              lim_next  = lim_v;
              sent_next = '0;
              idx_next  = '0;
              if (lim_v == '0) begin
                state_next = S_IDLE;
              end else begin
                state_next = S_FRD;
              end
            end
          endcase
        end else begin
          rd_pend_next = more;
          if (more) begin
            mem_re     = 1'b1;
            idx_d_next = idx;
            idx_next   = idx_inc;
          end
        end
      end

      // read entry i+1, write it to i in the following cycle
      S_SHIFT: begin
        if (rd_pend) begin
          mem_we = 1'b1;
          mem_wa = idx_d_dec[AW-1:0];
          mem_wd = rd_data;
        end
        rd_pend_next = more;
        if (more) begin
          mem_re     = 1'b1;
          idx_d_next = idx;
          idx_next   = idx_inc;
        end else if (!rd_pend) begin
          count_next = CW'(count - 1'b1);
          state_next = S_IDLE;
        end
      end

      // first read of the fanout walk
      S_FRD: begin
        if (more) begin
          mem_re     = 1'b1;
          idx_next   = idx_inc;
          state_next = S_FEV;
        end else begin
          state_next = S_IDLE;
        end
      end

      // evaluate one entry: skip the sender, else emit a copy when the slot frees
      S_FEV: begin
        if (hit) begin
          advance = 1'b1;
        end else if (slot_free) begin
          load      = 1'b1;
          sent_next = sent_inc;
          if (is_last) begin
            state_next = S_IDLE;
          end else begin
            advance = 1'b1;
          end
        end
        if (advance) begin
          if (more) begin
            mem_re   = 1'b1;
            idx_next = idx_inc;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    res_next = res;
    if (load) begin
      res_next.dest    = rd_data;
      res_next.origin  = sender;
      res_next.payload = payload;
      res_next.last    = is_last;
      res_valid_next   = 1'b1;
    end else if (out_stall) begin
      res_valid_next = res_valid;
    end else begin
      res_valid_next = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rd_pend   <= rd_pend_next;
      res_valid <= res_valid_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    kind    <= kind_next;
    sender  <= sender_next;
    payload <= payload_next;
    idx     <= idx_next;
    idx_d   <= idx_d_next;
    lim     <= lim_next;
    sent    <= sent_next;
    res     <= res_next;
  end

endmodule

>>> rtl/subscriber_table_fanout.sv
`timescale 1ns / 1ps
// one request at a time; table memory is walked one entry per cycle unless the output stalls
// lookup and add come first; join ends there
// leave: then the entries after the sender shift down one place
// message: then the fanout walk reads the entries in order, up to MAX_RESULTS copies
// reset clears the member count and control; table contents are not cleared

module subscriber_table_fanout #(
  parameter int TABLE_SIZE  = stf_pkg::TABLE_SIZE_DEF,
  parameter int MAX_RESULTS = stf_pkg::MAX_RESULTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stf_pkg::REQ_W-1:0]     req_type,
  input  logic [stf_pkg::ID_W-1:0]      sender_id,
  input  logic [stf_pkg::PAYLOAD_W-1:0] payload_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stf_pkg::ID_W-1:0]      dest_id,
  output logic [stf_pkg::ID_W-1:0]      origin_id,
  output logic [stf_pkg::PAYLOAD_W-1:0] payload_out,
  output logic                          last_copy
);
  import stf_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);

  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [ID_W-1:0] mem_wd;
  logic            mem_re;
  logic [AW-1:0]   mem_ra;
  logic [ID_W-1:0] rd_data;
  res_t            res;

  // member table storage
  stf_mem #(
    .DEPTH (TABLE_SIZE),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (rd_data)
  );

  // sequencer with shared compare and output register
  stf_ctrl #(
    .TABLE_SIZE  (TABLE_SIZE),
    .MAX_RESULTS (MAX_RESULTS),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .sender_id      (sender_id),
    .payload_handle (payload_handle),
    .res_valid      (out_valid),
    .out_stall      (out_stall),
    .res            (res),
    .mem_we         (mem_we),
    .mem_wa         (mem_wa),
    .mem_wd         (mem_wd),
    .mem_re         (mem_re),
    .mem_ra         (mem_ra),
    .rd_data        (rd_data)
  );

  assign dest_id     = res.dest;
  assign origin_id   = res.origin;
  assign payload_out = res.payload;
  assign last_copy   = res.last;

  // a request makes the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took a transaction and was not busy next cycle");

  // the sender never gets its own copy
  a_no_self_copy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dest_id != origin_id))
    else $error("broadcast copy addressed to its sender");

endmodule

>>> dv/subscriber_table_fanout_checker.sv
`timescale 1ns / 1ps

module subscriber_table_fanout_checker #(
  parameter int TABLE_SIZE  = stf_pkg::TABLE_SIZE_DEF,
  parameter int MAX_RESULTS = stf_pkg::MAX_RESULTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [stf_pkg::REQ_W-1:0]     req_type,
  input  logic [stf_pkg::ID_W-1:0]      sender_id,
  input  logic [stf_pkg::PAYLOAD_W-1:0] payload_handle,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [stf_pkg::ID_W-1:0]      dest_id,
  input  logic [stf_pkg::ID_W-1:0]      origin_id,
  input  logic [stf_pkg::PAYLOAD_W-1:0] payload_out,
  input  logic                          last_copy,
  output int                            fail_count,
  output int                            pending
);

  import stf_pkg::*;

  // shadow copy of the group roster
  logic [ID_W-1:0] roster [TABLE_SIZE];
  int              roster_len = 0;

  // copies still owed by the block, oldest first
  res_t copies_due [$];
  res_t head;
  int   mismatches = 0;

  initial fail_count = 0;
  initial pending = 0;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int roster_pos(input logic [ID_W-1:0] id);
    for (int i = 0; i < roster_len; i++) begin
      if (roster[i] == id) return i;
    end
    return -1;
  endfunction

  // apply one request to the roster and queue the copies it fans out
  task automatic apply_request(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] sender,
                               input logic [PAYLOAD_W-1:0] handle);
    int   pos;
    int   sent;
    bit   held;
    res_t copy;
    // every request enrolls its sender unless listed or full
    if (roster_pos(sender) < 0 && roster_len < TABLE_SIZE) begin
      roster[roster_len] = sender;
      roster_len++;
    end
    if (kind == REQ_JOIN) return;
    // leave: remove the sender, keep the order of the rest
    if (kind == REQ_LEAVE) begin
      pos = roster_pos(sender);
      if (pos >= 0) begin
        for (int i = pos; i < roster_len - 1; i++) roster[i] = roster[i + 1];
        roster_len--;
      end
      return;
    end
    // anything else broadcasts to every other member in roster order, up to MAX_RESULTS copies
    sent = 0;
    held = 1'b0;
    for (int i = 0; i < roster_len; i++) begin
      if (roster[i] == sender) continue;
      if (sent >= MAX_RESULTS) break;
      if (held) copies_due.push_back(copy);
      copy.dest    = roster[i];
      copy.origin  = sender;
      copy.payload = handle;
      copy.last    = 1'b0;
      held         = 1'b1;
      sent++;
    end
    if (held) begin
      copy.last = 1'b1;
      copies_due.push_back(copy);
    end
  endtask

  // watch both channels
  always @(posedge clk) begin
    if (rst) begin
      roster_len = 0;
      copies_due.delete();
    end else begin
      if (in_valid && !in_stall) apply_request(req_type, sender_id, payload_handle);
      if (out_valid && !out_stall) begin
        if (copies_due.size() == 0) begin
          report($sformatf("unexpected copy dest %h origin %h", dest_id, origin_id));
        end else begin
          head = copies_due.pop_front();
          if (dest_id !== head.dest)
            report($sformatf("dest_id %h, expected %h", dest_id, head.dest));
          if (origin_id !== head.origin)
            report($sformatf("origin_id %h, expected %h", origin_id, head.origin));
          if (payload_out !== head.payload)
            report($sformatf("payload_out %h, expected %h", payload_out, head.payload));
          if (last_copy !== head.last)
            report($sformatf("last_copy %b, expected %b (dest %h)", last_copy, head.last,
                             head.dest));
        end
      end
    end
    fail_count <= mismatches + (copies_due.size() > 0 ? 0 : 0);
    pending    <= copies_due.size();
  end

endmodule

>>> dv/subscriber_table_fanout_test.sv
`timescale 1ns / 1ps

module subscriber_table_fanout_test;

  import stf_pkg::*;

  // broadcast codes; anything other than join or leave is a broadcast
  localparam logic [REQ_W-1:0] REQ_POST  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = 2 * TABLE_SIZE_DEF + 8;
  localparam int ROUNDS       = 4;
  localparam int ROUND_ITEMS  = 34;
  localparam int POOL_SIZE    = 20;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [REQ_W-1:0]     req_type = '0;
  logic [ID_W-1:0]      sender_id = '0;
  logic [PAYLOAD_W-1:0] payload_handle = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ID_W-1:0]      dest_id;
  logic [ID_W-1:0]      origin_id;
  logic [PAYLOAD_W-1:0] payload_out;
  logic                 last_copy;

  logic                 calm = 1'b0;
  int                   fail_count;
  int                   pending;
  int                   cycles = 0;
  logic [ID_W-1:0]      id_pool [POOL_SIZE];

  always #5 clk = ~clk;

  subscriber_table_fanout i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .sender_id      (sender_id),
    .payload_handle (payload_handle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .dest_id        (dest_id),
    .origin_id      (origin_id),
    .payload_out    (payload_out),
    .last_copy      (last_copy)
  );

  subscriber_table_fanout_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .sender_id      (sender_id),
    .payload_handle (payload_handle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .dest_id        (dest_id),
    .origin_id      (origin_id),
    .payload_out    (payload_out),
    .last_copy      (last_copy),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // receiver backpressure, off during the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 19);
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("subscriber_table_fanout_test NOT OK");
      $finish;
    end
  end

  // one request transaction, with a random gap ahead of it
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id,
                              input logic [PAYLOAD_W-1:0] handle);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= kind;
    sender_id      <= id;
    payload_handle <= handle;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    int               leave_pct;
    int               pick;
    logic [REQ_W-1:0] kind;
    logic [ID_W-1:0]  id;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // grow the roster one bit at a time; the first has nobody to reach
    for (int i = 0; i < 16; i++) send_request(REQ_POST, ID_W'(1 << i), $urandom());
    // table full: join dropped, outsider broadcast reaches all sixteen
    send_request(REQ_JOIN, 16'hFFFF, 32'h0000_0000);
    send_request(REQ_POST, 16'hFFFF, 32'hFFFF_FFFF);
    // unused code from a member broadcasts too
    send_request(REQ_SPARE, 16'h0001, 32'h0000_0000);
    // leave from the middle, then leave of an outsider, which is enrolled and removed again
    send_request(REQ_LEAVE, 16'h0100, 32'hFFFF_FFFF);
    send_request(REQ_LEAVE, 16'hFFFF, 32'h1234_5678);
    // duplicate join, then leaves at the head and the tail
    send_request(REQ_JOIN, 16'h0001, 32'hA5A5_5A5A);
    send_request(REQ_LEAVE, 16'h0001, 32'h0000_0000);
    send_request(REQ_LEAVE, 16'h8000, 32'hFFFF_FFFF);
    send_request(REQ_POST, 16'h0000, 32'hDEAD_BEEF);

    // random rounds that alternate between draining and growing the roster
    for (int r = 0; r < ROUNDS; r++) begin
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      for (int k = 2; k < POOL_SIZE; k++) id_pool[k] = ID_W'($urandom());
      leave_pct = (r % 2 == 0) ? 50 : 10;
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        calm <= (r == 2 && n < 30);
        pick = $urandom_range(0, 99);
        if (pick < leave_pct) kind = REQ_LEAVE;
        else if (pick < leave_pct + 5) kind = REQ_SPARE;
        else if ((pick - leave_pct) % 2 == 0) kind = REQ_JOIN;
        else kind = REQ_POST;
        if ($urandom_range(0, 9) == 0) id = ID_W'($urandom());
        else id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_request(kind, id, $urandom());
      end
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // let the last copies drain, then a quiet tail for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("subscriber_table_fanout_test OK");
    end else begin
      $display("subscriber_table_fanout_test NOT OK");
    end
    $finish;
  end

endmodule

>>> subscriber_table_fanout.f
rtl/stf_pkg.sv
rtl/stf_mem.sv
rtl/stf_ctrl.sv
rtl/subscriber_table_fanout.sv
dv/subscriber_table_fanout_checker.sv
dv/subscriber_table_fanout_test.sv
